>>> rtl/bmf_pkg.sv
// shared types and constants of the binary morphology filter
`default_nettype none

package bmf_pkg;

    // pixel and register widths fixed by the interface
    localparam int PIX_W     = 8;
    localparam int MASK_BITS = 49;
    localparam int DIM_W     = 11;
    localparam int KDIM_W    = 3;
    localparam int CFG_IDX_W = 3;
    localparam int CFG_DAT_W = MASK_BITS;

    // register map
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_OPERATION    = 3'd0,
        CFG_KERNEL_ROWS  = 3'd1,
        CFG_KERNEL_COLS  = 3'd2,
        CFG_KERNEL_MASK  = 3'd3,
        CFG_IMAGE_WIDTH  = 3'd4,
        CFG_IMAGE_HEIGHT = 3'd5
    } t_cfg_index;

    // operation codes
    localparam logic OP_ERODE  = 1'b0;
    localparam logic OP_DILATE = 1'b1;

    // result pixel values
    localparam logic [PIX_W-1:0] FG_VALUE = 8'd255;
    localparam logic [PIX_W-1:0] BG_VALUE = 8'd0;

    // register reset values
    localparam logic                 RST_OPERATION    = OP_ERODE;
    localparam logic [KDIM_W-1:0]    RST_KERNEL_ROWS  = 3'd3;
    localparam logic [KDIM_W-1:0]    RST_KERNEL_COLS  = 3'd3;
    localparam logic [MASK_BITS-1:0] RST_KERNEL_MASK  = 49'd115591;
    localparam logic [DIM_W-1:0]     RST_IMAGE_WIDTH  = 11'd640;
    localparam logic [DIM_W-1:0]     RST_IMAGE_HEIGHT = 11'd480;

endpackage

`default_nettype wire

>>> rtl/binary_morphology_filter_unit.sv
// top level of the binary morphology filter: line store, window and result register
`default_nettype none

// Binary erosion / dilation over a raster pixel stream. Each grey input pixel
// (nonzero is foreground) produces exactly one result pixel of 0 or 255, and
// results come out in input order, trailing the input position by
// (rows/2)*width + cols/2. Erosion gives 255 when every active mask position
// of the kernel_rows x kernel_cols window is foreground, dilation when any is;
// positions nearer the frame edge than the window anchor give 0. Results that
// still belong to the previous frame's tail are 0 and flagged in tuser. The
// block takes one pixel per clock while the output is not stalled: a transfer
// is registered, the line store (one word per column holding that column of
// the last KERNEL_MAX+1 lines) is read in the same cycle, and the window stage
// then updates the store, evaluates the window and loads the result register
// once that register is free or being emptied. The sustained rate of one
// transfer per clock is set by the line store's single read-modify-write per
// pixel. After reset a clearing pass writes the line store to zero, one column
// per clock; the input stays not ready during that time while register writes
// are taken as usual. Configuration is meant to be written while the block
// holds no pixel in flight; a change takes effect from the next pixel.
module binary_morphology_filter_unit
    import bmf_pkg::*;
#(
    parameter int KERNEL_MAX = 7,
    parameter int WIDTH_MAX  = 1024,
    parameter int HEIGHT_MAX = 1024
) (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    // configuration write port
    input  wire logic                 i_cfg_we,
    input  wire logic [CFG_IDX_W-1:0] i_cfg_index,
    input  wire logic [CFG_DAT_W-1:0] i_cfg_wdata,
    // pixel input stream
    input  wire logic                 i_s_axis_tvalid,
    output      logic                 o_s_axis_tready,
    input  wire logic [PIX_W-1:0]     i_s_axis_tdata,   // [7:0] pixel
    // result stream
    output      logic                 o_m_axis_tvalid,
    input  wire logic                 i_m_axis_tready,
    output      logic [PIX_W-1:0]     o_m_axis_tdata,   // [7:0] filtered_pixel
    output      logic                 o_m_axis_tuser    // [0] from_previous_frame
);

    localparam int LINES  = KERNEL_MAX + 1;
    localparam int LINE_W = $clog2(LINES);
    localparam int COL_W  = $clog2(WIDTH_MAX);
    localparam int ROW_W  = $clog2(HEIGHT_MAX);
    localparam int W_W    = $clog2(WIDTH_MAX + 1);
    localparam int H_W    = $clog2(HEIGHT_MAX + 1);
    localparam int KR_W   = $clog2(KERNEL_MAX + 1);

    // configuration registers
    logic                 r_operation;
    logic [KDIM_W-1:0]    r_kernel_rows;
    logic [KDIM_W-1:0]    r_kernel_cols;
    logic [MASK_BITS-1:0] r_kernel_mask;
    logic [DIM_W-1:0]     r_image_width;
    logic [DIM_W-1:0]     r_image_height;

    // raster position of the next pixel; r_line follows the row modulo LINES
    logic [COL_W-1:0]  r_col;
    logic [ROW_W-1:0]  r_row;
    logic [LINE_W-1:0] r_line;

    // line store clearing pass
    logic             r_clr_busy;
    logic [COL_W-1:0] r_clr_addr;

    // line store: one word per column, one bit per line
    logic [LINES-1:0] r_mem [WIDTH_MAX];
    logic [LINES-1:0] r_rd_word;

    // window stage
    logic              r_s1_valid;
    logic [COL_W-1:0]  r_s1_col;
    logic [LINE_W-1:0] r_s1_line;
    logic              r_s1_fg;
    logic              r_s1_inside;
    logic              r_s1_prev;
    logic              r_s1_fwd;
    logic [LINES-1:0]  r_s1_fwd_word;
    logic [LINES-1:0]  r_win [KERNEL_MAX];

    // result register
    logic             r_out_valid;
    logic [PIX_W-1:0] r_out_pix;
    logic             r_out_prev;

    // effective sizes
    logic [W_W-1:0]  w;
    logic [H_W-1:0]  h;
    logic [KR_W-1:0] kr;
    logic [KR_W-1:0] kc;
    logic [KR_W-1:0] cy;
    logic [KR_W-1:0] cx;
    logic [KR_W-1:0] twice_cy;
    logic [KR_W-1:0] twice_cx;

    // position of the incoming pixel and of the one after it
    logic [COL_W-1:0]  c1;
    logic [ROW_W-1:0]  r1;
    logic [LINE_W-1:0] l1;
    logic [COL_W-1:0]  n_col;
    logic [ROW_W-1:0]  n_row;
    logic [LINE_W-1:0] n_line;
    logic              pos_inside;
    logic              pos_prev;

    // handshake
    logic s1_adv;
    logic in_ready;
    logic in_xfer;

    // window evaluation
    logic [LINES-1:0]  word_cur;
    logic [LINES-1:0]  word_new;
    logic [LINES-1:0]  cols   [KERNEL_MAX+1];
    logic [LINES-1:0]  colsel [KERNEL_MAX];
    logic [LINE_W-1:0] lidx   [KERNEL_MAX];
    logic              erode_ok;
    logic              dilate_hit;
    logic              win_hit;

    // line store write side
    logic             mem_we;
    logic [COL_W-1:0] mem_waddr;
    logic [LINES-1:0] mem_wdata;

    function automatic logic [LINE_W-1:0] line_inc(input logic [LINE_W-1:0] l);
        if (int'(l) == LINES - 1) begin
            return '0;
        end
        return l + LINE_W'(1);
    endfunction

    // ------------------------------------------------------------------
    // effective frame and kernel sizes: zero frame sizes act as one, large ones
    // saturate at the maximum
    // ------------------------------------------------------------------
    always_comb begin
        if (r_image_width == '0) begin
            w = W_W'(1);
        end else if (int'(r_image_width) > WIDTH_MAX) begin
            w = W_W'(WIDTH_MAX);
        end else begin
            w = W_W'(r_image_width);
        end

        if (r_image_height == '0) begin
            h = H_W'(1);
        end else if (int'(r_image_height) > HEIGHT_MAX) begin
            h = H_W'(HEIGHT_MAX);
        end else begin
            h = H_W'(r_image_height);
        end

        if (int'(r_kernel_rows) > KERNEL_MAX) begin
            kr = KR_W'(KERNEL_MAX);
        end else begin
            kr = KR_W'(r_kernel_rows);
        end

        if (int'(r_kernel_cols) > KERNEL_MAX) begin
            kc = KR_W'(KERNEL_MAX);
        end else begin
            kc = KR_W'(r_kernel_cols);
        end

        cy       = kr >> 1;
        cx       = kc >> 1;
        twice_cy = kr & ~KR_W'(1);
        twice_cx = kc & ~KR_W'(1);
    end

    // ------------------------------------------------------------------
    // raster position: counters left beyond a shrunk frame wrap first,
    // then the position advances past the incoming pixel
    // ------------------------------------------------------------------
    always_comb begin
        int  row_i;
        int  col_i;
        int  d;
        logic       wrap;
        logic [1:0] dsat;
        logic [1:0] wsat;
        logic [3:0] prod;

        wrap  = int'(r_col) >= int'(w);
        row_i = int'(r_row) + (wrap ? 1 : 0);
        c1    = wrap ? '0 : r_col;
        if (row_i >= int'(h)) begin
            r1 = '0;
            l1 = '0;
        end else begin
            r1 = ROW_W'(row_i);
            l1 = wrap ? line_inc(r_line) : r_line;
        end

        col_i = int'(c1) + 1;
        if (col_i >= int'(w)) begin
            n_col = '0;
            row_i = int'(r1) + 1;
            if (row_i >= int'(h)) begin
                n_row  = '0;
                n_line = '0;
            end else begin
                n_row  = ROW_W'(row_i);
                n_line = line_inc(l1);
            end
        end else begin
            n_col  = COL_W'(col_i);
            n_row  = r1;
            n_line = l1;
        end

        // full window lies inside the frame
        pos_inside = (int'(r1) >= int'(twice_cy)) && (int'(c1) >= int'(twice_cx));

        // output position still before the frame start: (r1-cy)*w + c1 < cx,
        // where cx is at most three so saturated two-bit factors suffice
        d    = int'(r1) - int'(cy);
        dsat = (d > 3) ? 2'd3 : 2'(d);
        wsat = (int'(w) > 3) ? 2'd3 : 2'(w);
        prod = {2'b00, dsat} * {2'b00, wsat};
        if (int'(r1) < int'(cy)) begin
            pos_prev = 1'b1;
        end else if (int'(c1) < int'(cx)) begin
            pos_prev = int'(prod) < (int'(cx) - int'(c1));
        end else begin
            pos_prev = 1'b0;
        end
    end

    // ------------------------------------------------------------------
    // handshake: the window stage moves on whenever the result register is
    // free or being emptied, so a pixel can enter on every clock
    // ------------------------------------------------------------------
    assign s1_adv          = r_s1_valid && (!r_out_valid || i_m_axis_tready);
    assign in_ready        = !r_clr_busy && (!r_s1_valid || s1_adv);
    assign in_xfer         = i_s_axis_tvalid && in_ready;
    assign o_s_axis_tready = in_ready;

    // ------------------------------------------------------------------
    // window stage: merge the new pixel into its column word, pick the
    // columns and lines under the kernel and reduce over the mask
    // ------------------------------------------------------------------
    always_comb begin
        word_cur            = r_s1_fwd ? r_s1_fwd_word : r_rd_word;
        word_new            = word_cur;
        word_new[r_s1_line] = r_s1_fg;

        // column words, newest first: the current column, then older ones
        cols[0] = word_new;
        for (int k = 1; k <= KERNEL_MAX; k++) begin
            cols[k] = r_win[k-1];
        end
    end

    always_comb begin
        int k;
        int lt;
        for (int kj = 0; kj < KERNEL_MAX; kj++) begin
            k = int'(twice_cx) - kj;
            if (k < 0) begin
                k = 0;
            end
            colsel[kj] = cols[KR_W'(k)];
        end
        for (int ki = 0; ki < KERNEL_MAX; ki++) begin
            lt = int'(r_s1_line) + LINES - int'(twice_cy) + ki;
            if (lt >= LINES) begin
                lt = lt - LINES;
            end
            if (lt >= LINES) begin
                lt = lt - LINES;
            end
            lidx[ki] = LINE_W'(lt);
        end
    end

    always_comb begin
        int   bit_i;
        logic act;
        logic fg;
        erode_ok   = 1'b1;
        dilate_hit = 1'b0;
        for (int ki = 0; ki < KERNEL_MAX; ki++) begin
            for (int kj = 0; kj < KERNEL_MAX; kj++) begin
                bit_i = ki * KERNEL_MAX + kj;
                act   = 1'b0;
                if (bit_i < MASK_BITS) begin
                    act = (ki < int'(kr)) && (kj < int'(kc)) && r_kernel_mask[bit_i];
                end
                fg = colsel[kj][lidx[ki]];
                if (act) begin
                    erode_ok   = erode_ok & fg;
                    dilate_hit = dilate_hit | fg;
                end
            end
        end
        win_hit = (r_operation == OP_DILATE) ? dilate_hit : erode_ok;
    end

    // ------------------------------------------------------------------
    // line store: read the incoming pixel's column on its transfer, write
    // back the updated word when it leaves the window stage
    // ------------------------------------------------------------------
    assign mem_we    = r_clr_busy || s1_adv;
    assign mem_waddr = r_clr_busy ? r_clr_addr : r_s1_col;
    assign mem_wdata = r_clr_busy ? '0 : word_new;

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_mem[mem_waddr] <= mem_wdata;
        end
        if (in_xfer) begin
            r_rd_word <= r_mem[c1];
        end
    end

    // ------------------------------------------------------------------
    // control state
    // ------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_operation    <= RST_OPERATION;
            r_kernel_rows  <= RST_KERNEL_ROWS;
            r_kernel_cols  <= RST_KERNEL_COLS;
            r_kernel_mask  <= RST_KERNEL_MASK;
            r_image_width  <= RST_IMAGE_WIDTH;
            r_image_height <= RST_IMAGE_HEIGHT;
            r_col          <= '0;
            r_row          <= '0;
            r_line         <= '0;
            r_clr_busy     <= 1'b1;
            r_clr_addr     <= '0;
            r_s1_valid     <= 1'b0;
            r_out_valid    <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_index)
                    CFG_OPERATION:    r_operation    <= i_cfg_wdata[0];
                    CFG_KERNEL_ROWS:  r_kernel_rows  <= i_cfg_wdata[KDIM_W-1:0];
                    CFG_KERNEL_COLS:  r_kernel_cols  <= i_cfg_wdata[KDIM_W-1:0];
                    CFG_KERNEL_MASK:  r_kernel_mask  <= i_cfg_wdata[MASK_BITS-1:0];
                    CFG_IMAGE_WIDTH:  r_image_width  <= i_cfg_wdata[DIM_W-1:0];
                    CFG_IMAGE_HEIGHT: r_image_height <= i_cfg_wdata[DIM_W-1:0];
                    default: begin
                    end
                endcase
            end

            if (r_clr_busy) begin
                r_clr_addr <= r_clr_addr + COL_W'(1);
                if (int'(r_clr_addr) == WIDTH_MAX - 1) begin
                    r_clr_busy <= 1'b0;
                end
            end

            if (in_xfer) begin
                r_col  <= n_col;
                r_row  <= n_row;
                r_line <= n_line;
            end

            if (in_xfer) begin
                r_s1_valid <= 1'b1;
            end else if (s1_adv) begin
                r_s1_valid <= 1'b0;
            end

            if (s1_adv) begin
                r_out_valid <= 1'b1;
            end else if (i_m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // ------------------------------------------------------------------
    // payload registers
    // ------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (in_xfer) begin
            r_s1_col      <= c1;
            r_s1_line     <= l1;
            r_s1_fg       <= |i_s_axis_tdata;
            r_s1_inside   <= pos_inside;
            r_s1_prev     <= pos_prev;
            // the word leaving the window stage now is not yet in the store
            r_s1_fwd      <= s1_adv && (r_s1_col == c1);
            r_s1_fwd_word <= word_new;
        end

        if (s1_adv) begin
            r_win[0] <= word_new;
            for (int k = 1; k < KERNEL_MAX; k++) begin
                r_win[k] <= r_win[k-1];
            end
            r_out_pix  <= (r_s1_inside && win_hit) ? FG_VALUE : BG_VALUE;
            r_out_prev <= r_s1_prev;
        end
    end

    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = r_out_pix;
    assign o_m_axis_tuser  = r_out_prev;

endmodule

`default_nettype wire

>>> tb/binary_morphology_filter_unit_tb.sv
// self-checking testbench of the binary morphology filter: directed table, random frames
module binary_morphology_filter_unit_tb
    import bmf_pkg::*;
();
    timeunit 1ns;
    timeprecision 1ps;

    localparam int KERNEL_MAX    = 7;
    localparam int WIDTH_MAX     = 1024;
    localparam int HEIGHT_MAX    = 1024;
    localparam int LINE_DEPTH    = KERNEL_MAX + 1;
    localparam int RANDOM_ITEMS  = 1050;
    localparam int CALM_ITEMS    = 80;     // tail of the run with no random pauses or stalls
    localparam int SETTLE_CYCLES = 4;
    localparam int LIMIT_CYCLES  = 400000;
    localparam int MAX_REPORTS   = 100;

    // register indexes outside the map, written to show they are ignored
    localparam logic [CFG_IDX_W-1:0] CFG_UNMAPPED_LO = 3'd6;
    localparam logic [CFG_IDX_W-1:0] CFG_UNMAPPED_HI = 3'd7;
    localparam logic [CFG_DAT_W-1:0] MASK_ALL        = '1;
    localparam logic [CFG_DAT_W-1:0] MASK_ONE        = CFG_DAT_W'(1);

    // one result as the block delivers it
    typedef struct packed {
        logic [PIX_W-1:0] pixel;
        logic             tail;
    } t_result;

    // directed stimulus: a register write, a pixel, or a pixel with a typed-in result
    typedef enum logic [1:0] {STEP_CFG, STEP_PIX, STEP_PIX_KNOWN} t_step_kind;
    typedef struct packed {
        t_step_kind           kind;
        logic [CFG_IDX_W-1:0] idx;
        logic [CFG_DAT_W-1:0] value;   // register value, or the pixel in the low byte
        logic [PIX_W-1:0]     want_pixel;
        logic                 want_tail;
    } t_step;

    localparam int DIR_LEN = 46;
    t_step dir_table [DIR_LEN] = '{
        // default setting after reset: 3x3 on 640 wide, lag 641, so all tail results
        '{STEP_PIX_KNOWN, '0, 'h00, BG_VALUE, 1'b1},
        '{STEP_PIX_KNOWN, '0, 'hFF, BG_VALUE, 1'b1},
        '{STEP_PIX_KNOWN, '0, 'h01, BG_VALUE, 1'b1},
        '{STEP_PIX_KNOWN, '0, 'h80, BG_VALUE, 1'b1},
        // zero frame size and zero kernel size: 1x1 frame, empty window, no lag
        '{STEP_CFG, CFG_IMAGE_WIDTH,  0, BG_VALUE, 1'b0},
        '{STEP_CFG, CFG_IMAGE_HEIGHT, 0, BG_VALUE, 1'b0},
        '{STEP_CFG, CFG_KERNEL_ROWS,  0, BG_VALUE, 1'b0},
        '{STEP_CFG, CFG_KERNEL_COLS,  0, BG_VALUE, 1'b0},
        '{STEP_CFG, CFG_KERNEL_MASK,  0, BG_VALUE, 1'b0},
        // empty window under erosion gives foreground
        '{STEP_PIX_KNOWN, '0, 'h00, FG_VALUE, 1'b0},
        '{STEP_CFG, CFG_OPERATION, OP_DILATE, BG_VALUE, 1'b0},
        // and under dilation background
        '{STEP_PIX_KNOWN, '0, 'hFF, BG_VALUE, 1'b0},
        // largest kernel, full mask, oversize frame saturated to 1024 x 1024
        '{STEP_CFG, CFG_KERNEL_ROWS,  7,        BG_VALUE, 1'b0},
        '{STEP_CFG, CFG_KERNEL_COLS,  7,        BG_VALUE, 1'b0},
        '{STEP_CFG, CFG_KERNEL_MASK,  MASK_ALL, BG_VALUE, 1'b0},
        '{STEP_CFG, CFG_IMAGE_WIDTH,  2047,     BG_VALUE, 1'b0},
        '{STEP_CFG, CFG_IMAGE_HEIGHT, 2047,     BG_VALUE, 1'b0},
        '{STEP_PIX_KNOWN, '0, 'hFF, BG_VALUE, 1'b1},
        '{STEP_PIX_KNOWN, '0, 'h00, BG_VALUE, 1'b1},
        // frame of two pixels, smaller than the lag of a 7x7 window
        '{STEP_CFG, CFG_IMAGE_WIDTH,  2, BG_VALUE, 1'b0},
        '{STEP_CFG, CFG_IMAGE_HEIGHT, 1, BG_VALUE, 1'b0},
        '{STEP_PIX_KNOWN, '0, 'h55, BG_VALUE, 1'b1},
        '{STEP_PIX_KNOWN, '0, 'hAA, BG_VALUE, 1'b1},
        // 5x4 frame, 3x3 erosion, mask with every bit set beyond the window too
        '{STEP_CFG, CFG_OPERATION,    OP_ERODE,             BG_VALUE, 1'b0},
        '{STEP_CFG, CFG_KERNEL_ROWS,  3,                    BG_VALUE, 1'b0},
        '{STEP_CFG, CFG_KERNEL_COLS,  3,                    BG_VALUE, 1'b0},
        '{STEP_CFG, CFG_IMAGE_WIDTH,  5,                    BG_VALUE, 1'b0},
        '{STEP_CFG, CFG_IMAGE_HEIGHT, 4,                    BG_VALUE, 1'b0},
        '{STEP_CFG, CFG_UNMAPPED_LO,  49'h1_2345_6789_ABCD, BG_VALUE, 1'b0},
        '{STEP_CFG, CFG_UNMAPPED_HI,  49'h0_FEDC_BA98_7654, BG_VALUE, 1'b0},
        '{STEP_PIX, '0, 'hFF, BG_VALUE, 1'b0},
        '{STEP_PIX, '0, 'hFF, BG_VALUE, 1'b0},
        '{STEP_PIX, '0, 'hFF, BG_VALUE, 1'b0},
        '{STEP_PIX, '0, 'h01, BG_VALUE, 1'b0},
        '{STEP_PIX, '0, 'hFF, BG_VALUE, 1'b0},
        '{STEP_PIX, '0, 'hFF, BG_VALUE, 1'b0},
        '{STEP_PIX, '0, 'hFF, BG_VALUE, 1'b0},
        '{STEP_PIX, '0, 'hFF, BG_VALUE, 1'b0},
        '{STEP_PIX, '0, 'hFF, BG_VALUE, 1'b0},
        '{STEP_PIX, '0, 'hFF, BG_VALUE, 1'b0},
        '{STEP_PIX, '0, 'h7F, BG_VALUE, 1'b0},
        '{STEP_PIX, '0, 'h00, BG_VALUE, 1'b0},
        // only bits outside the 3x3 window: effectively an empty mask
        '{STEP_CFG, CFG_KERNEL_MASK, MASK_ALL ^ RST_KERNEL_MASK, BG_VALUE, 1'b0},
        '{STEP_PIX, '0, 'hFF, BG_VALUE, 1'b0},
        '{STEP_PIX, '0, 'h00, BG_VALUE, 1'b0},
        '{STEP_PIX, '0, 'hFF, BG_VALUE, 1'b0}
    };

    // block ports
    logic                 i_clk;
    logic                 i_rst_n;
    logic                 i_cfg_we;
    logic [CFG_IDX_W-1:0] i_cfg_index;
    logic [CFG_DAT_W-1:0] i_cfg_wdata;
    logic                 i_s_axis_tvalid;
    logic                 o_s_axis_tready;
    logic [PIX_W-1:0]     i_s_axis_tdata;    // [7:0] pixel
    logic                 o_m_axis_tvalid;
    logic                 i_m_axis_tready;
    logic [PIX_W-1:0]     o_m_axis_tdata;    // [7:0] filtered_pixel
    logic                 o_m_axis_tuser;    // [0] from_previous_frame

    binary_morphology_filter_unit u_dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg_we        (i_cfg_we),
        .i_cfg_index     (i_cfg_index),
        .i_cfg_wdata     (i_cfg_wdata),
        .i_s_axis_tvalid (i_s_axis_tvalid),
        .o_s_axis_tready (o_s_axis_tready),
        .i_s_axis_tdata  (i_s_axis_tdata),
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (i_m_axis_tready),
        .o_m_axis_tdata  (o_m_axis_tdata),
        .o_m_axis_tuser  (o_m_axis_tuser)
    );

    // our own copy of the registers, reset values as after reset
    logic                 cfg_op     = RST_OPERATION;
    logic [KDIM_W-1:0]    cfg_rows   = RST_KERNEL_ROWS;
    logic [KDIM_W-1:0]    cfg_cols   = RST_KERNEL_COLS;
    logic [MASK_BITS-1:0] cfg_mask   = RST_KERNEL_MASK;
    logic [DIM_W-1:0]     cfg_width  = RST_IMAGE_WIDTH;
    logic [DIM_W-1:0]     cfg_height = RST_IMAGE_HEIGHT;

    // foreground bits of the last LINE_DEPTH lines and the raster position
    bit          fg_mem [LINE_DEPTH][WIDTH_MAX];
    int unsigned col_ctr = 0;
    int unsigned row_ctr = 0;

    t_result     pending_filtered [$];
    int unsigned errors          = 0;
    int unsigned random_sent     = 0;
    int unsigned src_gap_rate    = 3;   // 0 means the sender never pauses
    int unsigned sink_stall_rate = 5;   // 0 means the receiver never stalls
    bit          calm            = 1'b0;

    initial begin
        i_clk = 1'b0;
        forever #4 i_clk = ~i_clk;
    end

    // watchdog on the whole run
    initial begin
        repeat (LIMIT_CYCLES) @(posedge i_clk);
        $display("[FAIL] regression broken");
        $finish;
    end

    task automatic report_mismatch(input string what, input int unsigned got,
                                   input int unsigned want);
        if (errors < MAX_REPORTS)
            $display("%0t mismatch on %s: got %0d, expected %0d", $time, what, got, want);
        errors++;
    endtask

    // frame sizes of zero count as one, oversize ones saturate
    function automatic int unsigned eff_dim(input logic [DIM_W-1:0] v, input int unsigned hi);
        if (v == '0) return 1;
        return (v > hi) ? hi : v;
    endfunction

    // store one pixel and work out the result for the position trailing it
    function automatic t_result filter_pixel(input logic [PIX_W-1:0] pix);
        int unsigned w, h, kr, kc, cy, cx, pos, lag, p, orow, ocol, src_line;
        bit          acc;
        t_result     r;
        w  = eff_dim(cfg_width, WIDTH_MAX);
        h  = eff_dim(cfg_height, HEIGHT_MAX);
        // a 3-bit size never exceeds KERNEL_MAX, so no saturation is needed
        kr = cfg_rows;
        kc = cfg_cols;
        cy = kr / 2;
        cx = kc / 2;
        // counters left beyond a shrunk frame wrap before the pixel is taken
        if (col_ctr >= w) begin
            col_ctr = 0;
            row_ctr++;
        end
        if (row_ctr >= h) row_ctr = 0;
        fg_mem[row_ctr % LINE_DEPTH][col_ctr] = (pix != '0);
        pos     = row_ctr * w + col_ctr;
        lag     = cy * w + cx;
        r.pixel = BG_VALUE;
        r.tail  = (pos < lag);
        if (pos >= lag) begin
            p    = pos - lag;
            orow = p / w;
            ocol = p % w;
            // positions nearer the border than the anchor stay background
            if (orow >= cy && orow + cy < h && ocol >= cx && ocol + cx < w) begin
                acc = (cfg_op == OP_ERODE);
                for (int ki = 0; ki < kr; ki++) begin
                    src_line = (orow - cy + ki) % LINE_DEPTH;
                    for (int kj = 0; kj < kc; kj++) begin
                        if (cfg_mask[ki * KERNEL_MAX + kj]) begin
                            if (cfg_op == OP_ERODE && !fg_mem[src_line][ocol - cx + kj])
                                acc = 1'b0;
                            if (cfg_op == OP_DILATE && fg_mem[src_line][ocol - cx + kj])
                                acc = 1'b1;
                        end
                    end
                end
                r.pixel = acc ? FG_VALUE : BG_VALUE;
            end
        end
        col_ctr++;
        if (col_ctr >= w) begin
            col_ctr = 0;
            row_ctr++;
            if (row_ctr >= h) row_ctr = 0;
        end
        return r;
    endfunction

    // one register write, mirrored into our copy with the register's width
    task automatic cfg_write(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DAT_W-1:0] data);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_wdata <= data;
        case (idx)
            CFG_OPERATION:    cfg_op     = data[0];
            CFG_KERNEL_ROWS:  cfg_rows   = data[KDIM_W-1:0];
            CFG_KERNEL_COLS:  cfg_cols   = data[KDIM_W-1:0];
            CFG_KERNEL_MASK:  cfg_mask   = data[MASK_BITS-1:0];
            CFG_IMAGE_WIDTH:  cfg_width  = data[DIM_W-1:0];
            CFG_IMAGE_HEIGHT: cfg_height = data[DIM_W-1:0];
            default: ;
        endcase
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        @(posedge i_clk);
    endtask

    // half the time garbage rides above the register's width
    task automatic put_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DAT_W-1:0] val,
                           input int unsigned bits);
        logic [63:0]          rnd;
        logic [CFG_DAT_W-1:0] low_ones;
        rnd      = {$urandom, $urandom};
        low_ones = MASK_ALL >> (CFG_DAT_W - bits);
        if ($urandom_range(1, 0) == 1) val = val | (rnd[CFG_DAT_W-1:0] & ~low_ones);
        cfg_write(idx, val);
    endtask

    // hold the input off until every expected result has come out
    task automatic wait_idle();
        i_s_axis_tvalid <= 1'b0;
        @(posedge i_clk);
        while (pending_filtered.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    // offer one pixel until it is taken, then maybe pause
    task automatic send_pixel(input logic [PIX_W-1:0] pix, input bit use_known,
                              input t_result known);
        t_result r;
        i_s_axis_tvalid <= 1'b1;
        i_s_axis_tdata  <= pix;
        do @(posedge i_clk); while (!o_s_axis_tready);
        r = filter_pixel(pix);
        pending_filtered.push_back(use_known ? known : r);
        if (!calm && src_gap_rate != 0 && $urandom_range(src_gap_rate - 1, 0) == 0) begin
            i_s_axis_tvalid <= 1'b0;
            repeat ($urandom_range(14, 1)) @(posedge i_clk);
        end
    endtask

    // one setting, then a run of pixels over whole or partial frames
    task automatic random_phase(input int phase_no);
        logic [63:0]          rnd;
        logic [CFG_DAT_W-1:0] mask_v;
        logic [DIM_W-1:0]     dim_v;
        logic [PIX_W-1:0]     pix;
        int unsigned          frame, n_items, fg_pct;
        bit                   midway;
        wait_idle();
        case ($urandom_range(2, 0))
            0:       src_gap_rate = 0;
            1:       src_gap_rate = 3;
            default: src_gap_rate = 8;
        endcase
        case ($urandom_range(2, 0))
            0:       sink_stall_rate = 0;
            1:       sink_stall_rate = 4;
            default: sink_stall_rate = 10;
        endcase
        if ($urandom_range(3, 0) != 0) put_reg(CFG_OPERATION, $urandom_range(1, 0), 1);
        if ($urandom_range(3, 0) != 0) put_reg(CFG_KERNEL_ROWS, $urandom_range(7, 0), KDIM_W);
        if ($urandom_range(3, 0) != 0) put_reg(CFG_KERNEL_COLS, $urandom_range(7, 0), KDIM_W);
        if ($urandom_range(3, 0) != 0) begin
            rnd = {$urandom, $urandom};
            case ($urandom_range(7, 0))
                0:       mask_v = '0;
                1:       mask_v = MASK_ALL;
                2:       mask_v = RST_KERNEL_MASK;
                3:       mask_v = MASK_ONE << $urandom_range(MASK_BITS - 1, 0);
                4:       mask_v = ~(MASK_ONE << $urandom_range(MASK_BITS - 1, 0));
                default: mask_v = rnd[CFG_DAT_W-1:0];
            endcase
            put_reg(CFG_KERNEL_MASK, mask_v, MASK_BITS);
        end
        // mostly narrow frames, so the window reaches the interior quickly
        if ($urandom_range(3, 0) != 0) begin
            case ($urandom_range(31, 0))
                0:       dim_v = '0;
                1:       dim_v = '1;
                2:       dim_v = WIDTH_MAX;
                3:       dim_v = $urandom_range(2047, 13);
                4, 5:    dim_v = $urandom_range(40, 13);
                default: dim_v = $urandom_range(12, 1);
            endcase
            put_reg(CFG_IMAGE_WIDTH, dim_v, DIM_W);
        end
        if ($urandom_range(3, 0) != 0) begin
            case ($urandom_range(31, 0))
                0:       dim_v = '0;
                1:       dim_v = '1;
                2:       dim_v = $urandom_range(HEIGHT_MAX, 11);
                default: dim_v = $urandom_range(10, 1);
            endcase
            put_reg(CFG_IMAGE_HEIGHT, dim_v, DIM_W);
        end
        frame = eff_dim(cfg_width, WIDTH_MAX) * eff_dim(cfg_height, HEIGHT_MAX);
        if (frame > 200) n_items = $urandom_range(40, 10);
        else             n_items = frame * $urandom_range(3, 1) + $urandom_range(frame, 0);
        if (n_items > 150) n_items = 150;
        case ($urandom_range(3, 0))
            0:       fg_pct = 15;
            1:       fg_pct = 50;
            2:       fg_pct = 85;
            default: fg_pct = 100;
        endcase
        midway = (phase_no == 2) || ($urandom_range(7, 0) == 0);
        for (int i = 0; i < n_items; i++) begin
            calm = (random_sent >= RANDOM_ITEMS - CALM_ITEMS);
            // sender waits for the block to empty in the middle of a frame
            if (midway && i == n_items / 2) wait_idle();
            pix = ($urandom_range(99, 0) < fg_pct) ? PIX_W'($urandom_range(255, 1)) : '0;
            send_pixel(pix, 1'b0, '0);
            random_sent++;
        end
    endtask

    // receiver: stalls in random bursts, none once the run calms down
    initial begin
        i_m_axis_tready <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (!calm && sink_stall_rate != 0 &&
                $urandom_range(sink_stall_rate - 1, 0) == 0) begin
                i_m_axis_tready <= 1'b0;
                repeat ($urandom_range(14, 1)) @(posedge i_clk);
            end
            i_m_axis_tready <= 1'b1;
        end
    end

    // every result transfer against the oldest expectation
    always @(posedge i_clk) begin : result_check
        t_result want;
        if (i_rst_n && o_m_axis_tvalid && i_m_axis_tready) begin
            if (pending_filtered.size() == 0) begin
                report_mismatch("result with nothing expected", o_m_axis_tdata, 0);
            end else begin
                want = pending_filtered.pop_front();
                if (o_m_axis_tdata !== want.pixel)
                    report_mismatch("filtered_pixel", o_m_axis_tdata, want.pixel);
                if (o_m_axis_tuser !== want.tail)
                    report_mismatch("from_previous_frame", o_m_axis_tuser, want.tail);
            end
        end
    end

    initial begin
        int phase_no;
        i_rst_n         <= 1'b0;
        i_cfg_we        <= 1'b0;
        i_cfg_index     <= '0;
        i_cfg_wdata     <= '0;
        i_s_axis_tvalid <= 1'b0;
        i_s_axis_tdata  <= '0;
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        // the clearing pass after reset shows up as a long not-ready on the input

        for (int i = 0; i < DIR_LEN; i++) begin
            case (dir_table[i].kind)
                STEP_CFG: begin
                    wait_idle();
                    cfg_write(dir_table[i].idx, dir_table[i].value);
                end
                STEP_PIX:
                    send_pixel(dir_table[i].value[PIX_W-1:0], 1'b0, '0);
                default:
                    send_pixel(dir_table[i].value[PIX_W-1:0], 1'b1,
                               '{dir_table[i].want_pixel, dir_table[i].want_tail});
            endcase
        end

        phase_no = 0;
        while (random_sent < RANDOM_ITEMS) begin
            random_phase(phase_no);
            phase_no++;
        end

        wait_idle();
        repeat (8) @(posedge i_clk);
        if (pending_filtered.size() != 0)
            report_mismatch("results never delivered", 0, pending_filtered.size());
        if (errors == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

endmodule
